// ===== hw/rtl/b64d_pkg.sv =====
// Package for the base64 stream decoder: job record, sextet mapping, flush helper.
// No dependencies.
package b64d_pkg;

   localparam int unsigned BYTE_W     = 8;
   localparam int unsigned SEXTET_W   = 6;
   localparam int unsigned BUF_W      = 18;
   localparam int unsigned JOB_BYTES  = 3;

   localparam logic [7:0] CHAR_PLUS  = 8'h2B;
   localparam logic [7:0] CHAR_SLASH = 8'h2F;

   // Byte count codes in a job
   localparam logic [1:0] CNT_ONE   = 2'd1;
   localparam logic [1:0] CNT_TWO   = 2'd2;
   localparam logic [1:0] CNT_THREE = 2'd3;

   // Up to three output bytes; bytes[0] goes out first. n is the byte count.
   typedef struct packed {
      logic [JOB_BYTES-1:0][BYTE_W-1:0] bytes;
      logic [1:0]                       n;
   } job_type;

   // Decoder state seen by the top level
   typedef struct packed {
      logic       stopped;
      logic [1:0] count;
   } front_status_type;

   // Returns {invalid, sextet}
   function automatic logic [SEXTET_W:0] sextet_of(input logic [7:0] ch);
      logic [7:0] tmp;
      tmp = 8'd0;
      if (ch inside {[8'h41:8'h5A]}) begin
         tmp = ch - 8'h41;
         return {1'b0, tmp[SEXTET_W-1:0]};
      end else if (ch inside {[8'h61:8'h7A]}) begin
         tmp = ch - 8'd71;
         return {1'b0, tmp[SEXTET_W-1:0]};
      end else if (ch inside {[8'h30:8'h39]}) begin
         tmp = ch + 8'd4;
         return {1'b0, tmp[SEXTET_W-1:0]};
      end else if (ch == CHAR_PLUS) begin
         return {1'b0, 6'd62};
      end else if (ch == CHAR_SLASH) begin
         return {1'b0, 6'd63};
      end
      return {1'b1, 6'd0};
   endfunction

   // Bytes of a partial group: n sextets give n-1 bytes
   function automatic job_type flush_job(input logic [BUF_W-1:0] buf_v,
                                         input logic [1:0]       cnt);
      job_type j;
      j = '0;
      case (cnt)
         CNT_TWO: begin
            j.bytes[0] = buf_v[11:4];
            j.n        = CNT_ONE;
         end
         CNT_THREE: begin
            j.bytes[0] = buf_v[17:10];
            j.bytes[1] = buf_v[9:2];
            j.n        = CNT_TWO;
         end
         default: begin
            j.n = 2'd0;
         end
      endcase
      return j;
   endfunction

endpackage

// ===== hw/rtl/base64_stream_decoder.sv =====
// Top level of the base64 stream decoder: front end, job queue, back end.
// Depends on b64d_pkg, b64d_front, b64d_queue, b64d_back.
//
// Takes one base64 character per req transfer (tlast marks the last character
// of a string) and returns the decoded bytes on rsp, one byte per transfer,
// with rsp_tlast set on the last byte that a character produced. Four sextets
// give three bytes; '=' or any non-alphabet character flushes the partial
// group (n sextets give n-1 bytes) and the rest of the string is dropped up to
// its tlast, which also flushes a partial group. The front end decides a
// character's bytes in the cycle it is accepted, so req takes one character
// per cycle while the QUEUE_DEPTH-entry job queue has room. The back end sends
// one byte per cycle while rsp_tready is high, so the output sets the sustained
// rate: a character that completes a group gives three bytes on rsp, one that
// flushes three sextets two, others one or none.
// A result waiting on rsp does not block req until the queue is full.
module base64_stream_decoder #(
   parameter int unsigned QUEUE_DEPTH = 2   // job queue entries, 2 or more
) (
   input  logic       clock,
   input  logic       reset,
   // input: one character per transfer
   input  logic       req_tvalid,
   output logic       req_tready,
   input  logic [7:0] req_tdata,    // [7:0] symbol
   input  logic       req_tlast,    // end_of_string
   // output: one decoded byte per transfer
   output logic       rsp_tvalid,
   input  logic       rsp_tready,
   output logic [7:0] rsp_tdata,    // [7:0] data_byte
   output logic       rsp_tlast     // run_last
);
   import b64d_pkg::*;

   localparam int unsigned LVL_W = $clog2(QUEUE_DEPTH+1);

   logic                push_valid, push_ready;
   job_type             push_data;
   logic                pop_valid, pop_ready;
   job_type             pop_data;
   logic [LVL_W-1:0]    q_level;
   front_status_type    status;

   b64d_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_data  (push_data),
      .status     (status)
   );

   b64d_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_data  (push_data),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_data   (pop_data),
      .level      (q_level)
   );

   b64d_back u_back (
      .clock      (clock),
      .reset      (reset),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_data   (pop_data),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

   // A stopped decoder holds no sextets
   a_stopped_empty: assert property (@(posedge clock) disable iff (reset)
      status.stopped |-> (status.count == 2'd0))
      else $error("stopped with sextets buffered");

   // tlast on a stopped string restarts decoding
   a_restart: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready && req_tlast && status.stopped)
      |=> (!status.stopped && status.count == 2'd0))
      else $error("decoder did not restart at end of string");

   // Queue level stays within its depth
   a_queue_bound: assert property (@(posedge clock) disable iff (reset)
      q_level <= LVL_W'(QUEUE_DEPTH))
      else $error("job queue overflow");

   // Input is taken only while the queue has room
   a_ready_room: assert property (@(posedge clock) disable iff (reset)
      req_tready |-> (q_level != LVL_W'(QUEUE_DEPTH)))
      else $error("input ready with queue full");

endmodule

// ===== hw/rtl/b64d_front.sv =====
// Front end: accepts characters, maps them to sextets and builds byte jobs.
// Depends on b64d_pkg.
module b64d_front (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_tvalid,
   output logic                      req_tready,
   input  logic [7:0]                req_tdata,
   input  logic                      req_tlast,
   output logic                      push_valid,
   input  logic                      push_ready,
   output b64d_pkg::job_type         push_data,
   output b64d_pkg::front_status_type status
);
   import b64d_pkg::*;

   logic [BUF_W-1:0]    buf_ff, buf_in;
   logic [1:0]          count_ff, count_in;
   logic                stopped_ff, stopped_in;
   logic [SEXTET_W:0]   sx;
   logic [BUF_W-1:0]    grown_buf;
   logic [1:0]          grown_count;
   logic                accept;
   job_type             job;

   assign req_tready = push_ready;
   assign accept     = req_tvalid && req_tready;
   assign sx         = sextet_of(req_tdata);
   assign grown_buf  = {buf_ff[BUF_W-SEXTET_W-1:0], sx[SEXTET_W-1:0]};
   assign grown_count = count_ff + 2'd1;

   always_comb begin
      buf_in     = buf_ff;
      count_in   = count_ff;
      stopped_in = stopped_ff;
      job        = '0;
      if (accept) begin
         if (stopped_ff) begin
            // ignore until end of string
            if (req_tlast) begin
               stopped_in = 1'b0;
               buf_in     = '0;
               count_in   = '0;
            end
         end else if (!sx[SEXTET_W]) begin
            if (count_ff == CNT_THREE) begin
               job.bytes[0] = buf_ff[17:10];
               job.bytes[1] = {buf_ff[9:2]};
               job.bytes[2] = {buf_ff[1:0], sx[SEXTET_W-1:0]};
               job.n        = CNT_THREE;
               buf_in       = '0;
               count_in     = '0;
            end else if (req_tlast) begin
               job      = flush_job(grown_buf, grown_count);
               buf_in   = '0;
               count_in = '0;
            end else begin
               buf_in   = grown_buf;
               count_in = grown_count;
            end
         end else begin
            // pad or bad character: flush, and stop unless it ends the string
            job        = flush_job(buf_ff, count_ff);
            buf_in     = '0;
            count_in   = '0;
            stopped_in = !req_tlast;
         end
      end
   end

   assign push_valid = accept && (job.n != 2'd0);
   assign push_data  = job;
   assign status     = '{stopped: stopped_ff, count: count_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         buf_ff     <= '0;
         count_ff   <= '0;
         stopped_ff <= 1'b0;
      end else begin
         buf_ff     <= buf_in;
         count_ff   <= count_in;
         stopped_ff <= stopped_in;
      end
   end

endmodule

// ===== hw/rtl/b64d_queue.sv =====
// Short job queue between front and back end.
// Depends on b64d_pkg.
module b64d_queue #(
   parameter int unsigned DEPTH = 2
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         push_valid,
   output logic                         push_ready,
   input  b64d_pkg::job_type            push_data,
   output logic                         pop_valid,
   input  logic                         pop_ready,
   output b64d_pkg::job_type            pop_data,
   output logic [$clog2(DEPTH+1)-1:0]   level
);
   import b64d_pkg::*;

   localparam int unsigned PTR_W = $clog2(DEPTH);
   localparam int unsigned LVL_W = $clog2(DEPTH+1);
   localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
   localparam logic [LVL_W-1:0] FULL_LVL = LVL_W'(DEPTH);

   job_type          mem_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [LVL_W-1:0] level_ff, level_in;
   logic             do_push, do_pop;

   assign push_ready = (level_ff != FULL_LVL);
   assign pop_valid  = (level_ff != '0);
   assign do_push    = push_valid && push_ready;
   assign do_pop     = pop_valid && pop_ready;
   assign pop_data   = mem_ff[rd_ptr_ff];
   assign level      = level_ff;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      level_in  = level_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == LAST_PTR) ? '0 : wr_ptr_ff + PTR_W'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == LAST_PTR) ? '0 : rd_ptr_ff + PTR_W'(1);
      end
      if (do_push && !do_pop) begin
         level_in = level_ff + LVL_W'(1);
      end else if (do_pop && !do_push) begin
         level_in = level_ff - LVL_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         level_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         level_ff  <= level_in;
      end
   end

endmodule

// ===== hw/rtl/b64d_back.sv =====
// Back end: sends the bytes of each job one per transfer, tlast on the final one.
// Depends on b64d_pkg.
module b64d_back (
   input  logic              clock,
   input  logic              reset,
   input  logic              pop_valid,
   output logic              pop_ready,
   input  b64d_pkg::job_type pop_data,
   output logic              rsp_tvalid,
   input  logic              rsp_tready,
   output logic [7:0]        rsp_tdata,
   output logic              rsp_tlast
);
   import b64d_pkg::*;

   job_type    job_ff;
   logic [1:0] idx_ff, idx_in;
   logic       busy_ff, busy_in;
   logic       last_byte, xfer, take;

   assign last_byte  = (idx_ff == (job_ff.n - 2'd1));
   assign rsp_tvalid = busy_ff;
   assign rsp_tdata  = job_ff.bytes[idx_ff];
   assign rsp_tlast  = last_byte;
   assign xfer       = busy_ff && rsp_tready;
   assign pop_ready  = !busy_ff || (rsp_tready && last_byte);
   assign take       = pop_valid && pop_ready;

   always_comb begin
      idx_in  = idx_ff;
      busy_in = busy_ff;
      if (take) begin
         idx_in  = '0;
         busy_in = 1'b1;
      end else if (xfer && last_byte) begin
         busy_in = 1'b0;
      end else if (xfer) begin
         idx_in = idx_ff + 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         job_ff <= pop_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff  <= '0;
         busy_ff <= 1'b0;
      end else begin
         idx_ff  <= idx_in;
         busy_ff <= busy_in;
      end
   end

endmodule
